[rtl/m3i_pkg.sv]
// Package for the 3x3 matrix inverse unit: widths, pipeline depths, cofactor index tables.
`timescale 1ns / 1ps
package m3i_pkg;

    // Q16.16 entry width and derived widths
    localparam int ENT_W   = 32;
    localparam int PROD_W  = 2 * ENT_W;          // one entry product
    localparam int COF_W   = PROD_W + 1;         // difference of two products
    localparam int HALF_W  = COF_W - ENT_W;      // upper slice of a cofactor
    localparam int PP_W    = ENT_W + HALF_W;     // partial product width
    localparam int TERM_W  = PP_W + ENT_W;       // entry times cofactor
    localparam int SUM_W   = TERM_W + 2;         // sum of three terms
    localparam int NUM_ENT = 9;

    // Stage counts: 7 front stages, one stage per quotient bit, output register
    localparam int PRE_STAGES = 7;
    localparam int DIV_STEPS  = ENT_W;
    localparam int LATENCY    = PRE_STAGES + DIV_STEPS + 1;

    localparam logic [ENT_W-1:0] SAT_POS = {1'b0, {(ENT_W-1){1'b1}}};
    localparam logic [ENT_W-1:0] SAT_NEG = {1'b1, {(ENT_W-1){1'b0}}};

    typedef logic [3:0] t_idx;
    typedef t_idx t_idx_tab [NUM_ENT];

    // cofactor k = m[A]*m[B] - m[C]*m[D]
    localparam t_idx_tab CF_A = '{4'd4, 4'd5, 4'd3, 4'd2, 4'd0, 4'd1, 4'd1, 4'd2, 4'd0};
    localparam t_idx_tab CF_B = '{4'd8, 4'd6, 4'd7, 4'd7, 4'd8, 4'd6, 4'd5, 4'd3, 4'd4};
    localparam t_idx_tab CF_C = '{4'd5, 4'd3, 4'd4, 4'd1, 4'd2, 4'd0, 4'd2, 4'd0, 4'd1};
    localparam t_idx_tab CF_D = '{4'd7, 4'd8, 4'd6, 4'd8, 4'd6, 4'd7, 4'd4, 4'd5, 4'd3};

    // Signed saturation of a quotient given as sign, overflow flag and magnitude
    function automatic logic [ENT_W-1:0] quo_sat(input logic neg, input logic ovf,
                                                 input logic [ENT_W-1:0] q);
        logic [ENT_W-1:0] res;
        if (neg) begin
            if (ovf || q >= SAT_NEG) res = SAT_NEG;
            else                     res = ~q + ENT_W'(1);
        end else begin
            if (ovf || q > SAT_POS)  res = SAT_POS;
            else                     res = q;
        end
        return res;
    endfunction

endpackage

[rtl/matrix3x3_inverse_unit.sv]
// Pipelined 3x3 matrix inverse and determinant, adjugate method, Q16.16.
// Pipeline: the result strobe follows the start transfer through 7 front stages,
//   32 restoring-divider stages at one quotient bit each and one output register.
// Throughput: one matrix per cycle; busy is always low, the divider stages set the depth.
// Reset (synchronous, active low) clears only the valid bits; items in flight are dropped.
// The receiver cannot stall: each result shows for one cycle with o_strobe.
`timescale 1ns / 1ps
module matrix3x3_inverse_unit
    import m3i_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic signed [ENT_W-1:0] i_a00,
    input  logic signed [ENT_W-1:0] i_a01,
    input  logic signed [ENT_W-1:0] i_a02,
    input  logic signed [ENT_W-1:0] i_a10,
    input  logic signed [ENT_W-1:0] i_a11,
    input  logic signed [ENT_W-1:0] i_a12,
    input  logic signed [ENT_W-1:0] i_a20,
    input  logic signed [ENT_W-1:0] i_a21,
    input  logic signed [ENT_W-1:0] i_a22,
    output logic                    o_strobe,
    output logic signed [ENT_W-1:0] o_inv00,
    output logic signed [ENT_W-1:0] o_inv01,
    output logic signed [ENT_W-1:0] o_inv02,
    output logic signed [ENT_W-1:0] o_inv10,
    output logic signed [ENT_W-1:0] o_inv11,
    output logic signed [ENT_W-1:0] o_inv12,
    output logic signed [ENT_W-1:0] o_inv20,
    output logic signed [ENT_W-1:0] o_inv21,
    output logic signed [ENT_W-1:0] o_inv22,
    output logic signed [ENT_W-1:0] o_det_value,
    output logic                    o_singular
);

    localparam int LAST_VLD = PRE_STAGES + DIV_STEPS;

    logic signed [ENT_W-1:0] in_m [NUM_ENT];

    // Valid bits, one per stage
    logic [LAST_VLD:1] r_vld;

    // Front stage registers
    logic signed [PROD_W-1:0] r_p    [2*NUM_ENT];
    logic signed [ENT_W-1:0]  r_row1 [3];
    logic signed [COF_W-1:0]  r_c    [NUM_ENT];
    logic signed [ENT_W-1:0]  r_row2 [3];
    logic signed [PP_W-1:0]   r_pl   [3];
    logic signed [PP_W-1:0]   r_ph   [3];
    logic signed [TERM_W-1:0] r_t    [3];
    logic signed [SUM_W-1:0]  r_sum;
    logic [PROD_W-1:0]        r_dq;
    logic                     r_dneg6;

    // Cofactor magnitude and sign, delayed from stage 3 to stage 6
    logic [PROD_W-1:0] r_cm [4][NUM_ENT];
    logic              r_cn [4][NUM_ENT];

    // Divider pipeline, index 0 loaded by stage 7
    logic [ENT_W-1:0] r_rem  [DIV_STEPS+1][NUM_ENT];
    logic [ENT_W-1:0] r_qd   [DIV_STEPS+1][NUM_ENT];
    logic             r_ovf  [DIV_STEPS+1][NUM_ENT];
    logic             r_qneg [DIV_STEPS+1][NUM_ENT];
    logic [ENT_W-1:0] r_dmag [DIV_STEPS+1];
    logic [ENT_W-1:0] r_det  [DIV_STEPS+1];
    logic             r_sing [DIV_STEPS+1];

    // Output registers
    logic [ENT_W-1:0] r_inv [NUM_ENT];
    logic [ENT_W-1:0] r_det_o;
    logic             r_sing_o;
    logic             r_strobe;

    assign busy = 1'b0;

    assign in_m[0] = i_a00;
    assign in_m[1] = i_a01;
    assign in_m[2] = i_a02;
    assign in_m[3] = i_a10;
    assign in_m[4] = i_a11;
    assign in_m[5] = i_a12;
    assign in_m[6] = i_a20;
    assign in_m[7] = i_a21;
    assign in_m[8] = i_a22;

    // Valid shift line and output strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_vld    <= {r_vld[LAST_VLD-1:1], start & ~busy};
            r_strobe <= r_vld[LAST_VLD];
        end
    end

    // Stages 1-4: products, cofactors, partial products and terms of the determinant
    genvar k, s;
    generate
        for (k = 0; k < NUM_ENT; k++) begin : g_cof
            always_ff @(posedge i_clk) begin
                r_p[2*k]   <= PROD_W'(in_m[CF_A[k]]) * PROD_W'(in_m[CF_B[k]]);
                r_p[2*k+1] <= PROD_W'(in_m[CF_C[k]]) * PROD_W'(in_m[CF_D[k]]);
                r_c[k]     <= COF_W'(r_p[2*k]) - COF_W'(r_p[2*k+1]);
                r_cn[0][k] <= r_c[k][COF_W-1];
                r_cm[0][k] <= r_c[k][COF_W-1] ? PROD_W'(-r_c[k]) : PROD_W'(r_c[k]);
                r_cn[1][k] <= r_cn[0][k];
                r_cm[1][k] <= r_cm[0][k];
                r_cn[2][k] <= r_cn[1][k];
                r_cm[2][k] <= r_cm[1][k];
                r_cn[3][k] <= r_cn[2][k];
                r_cm[3][k] <= r_cm[2][k];
            end
        end
        for (k = 0; k < 3; k++) begin : g_row
            always_ff @(posedge i_clk) begin
                r_row1[k] <= in_m[k];
                r_row2[k] <= r_row1[k];
                r_pl[k]   <= PP_W'($signed({1'b0, r_c[k][ENT_W-1:0]})) * PP_W'(r_row2[k]);
                r_ph[k]   <= PP_W'($signed(r_c[k][COF_W-1:ENT_W])) * PP_W'(r_row2[k]);
                r_t[k]    <= (TERM_W'(r_ph[k]) <<< ENT_W) + TERM_W'(r_pl[k]);
            end
        end
    endgenerate

    // Stages 5-6: determinant sum, then magnitude truncated to Q16.16
    logic [SUM_W-1:0] dmag_full;
    assign dmag_full = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);

    always_ff @(posedge i_clk) begin
        r_sum   <= SUM_W'(r_t[0]) + SUM_W'(r_t[1]) + SUM_W'(r_t[2]);
        r_dneg6 <= r_sum[SUM_W-1];
        r_dq    <= dmag_full[PROD_W+ENT_W-1:ENT_W];
    end

    // Stage 7: saturated determinant, divisor, divider setup
    logic [ENT_W-1:0] n_det, n_dmag;
    always_comb begin
        if (r_dneg6) begin
            if (r_dq >= PROD_W'(SAT_NEG)) begin
                n_det  = SAT_NEG;
                n_dmag = SAT_NEG;
            end else begin
                n_det  = ~r_dq[ENT_W-1:0] + ENT_W'(1);
                n_dmag = r_dq[ENT_W-1:0];
            end
        end else begin
            if (r_dq > PROD_W'(SAT_POS)) begin
                n_det  = SAT_POS;
                n_dmag = SAT_POS;
            end else begin
                n_det  = r_dq[ENT_W-1:0];
                n_dmag = r_dq[ENT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_det[0]  <= n_det;
        r_dmag[0] <= n_dmag;
        r_sing[0] <= (r_dq == '0);
    end

    generate
        for (k = 0; k < NUM_ENT; k++) begin : g_dsetup
            always_ff @(posedge i_clk) begin
                r_rem[0][k]  <= r_cm[3][k][PROD_W-1:ENT_W];
                r_qd[0][k]   <= r_cm[3][k][ENT_W-1:0];
                r_ovf[0][k]  <= (r_cm[3][k][PROD_W-1:ENT_W] >= n_dmag);
                r_qneg[0][k] <= r_cn[3][k] ^ r_dneg6;
            end
        end

        // Restoring divider: one quotient bit per stage
        for (s = 0; s < DIV_STEPS; s++) begin : g_step
            always_ff @(posedge i_clk) begin
                r_dmag[s+1] <= r_dmag[s];
                r_det[s+1]  <= r_det[s];
                r_sing[s+1] <= r_sing[s];
            end
            for (k = 0; k < NUM_ENT; k++) begin : g_lane
                logic [ENT_W:0] trial;
                logic           ge;
                assign trial = {r_rem[s][k], r_qd[s][k][ENT_W-1]};
                assign ge    = (trial >= {1'b0, r_dmag[s]});
                always_ff @(posedge i_clk) begin
                    r_rem[s+1][k]  <= ge ? ENT_W'(trial - {1'b0, r_dmag[s]})
                                         : trial[ENT_W-1:0];
                    r_qd[s+1][k]   <= {r_qd[s][k][ENT_W-2:0], ge};
                    r_ovf[s+1][k]  <= r_ovf[s][k];
                    r_qneg[s+1][k] <= r_qneg[s][k];
                end
            end
        end

        // Output stage: saturate, zero on singular, transpose the adjugate
        for (k = 0; k < NUM_ENT; k++) begin : g_out
            always_ff @(posedge i_clk) begin
                r_inv[(k%3)*3 + k/3] <= r_sing[DIV_STEPS] ? '0 :
                    quo_sat(r_qneg[DIV_STEPS][k], r_ovf[DIV_STEPS][k], r_qd[DIV_STEPS][k]);
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        r_det_o  <= r_det[DIV_STEPS];
        r_sing_o <= r_sing[DIV_STEPS];
    end

    assign o_strobe    = r_strobe;
    assign o_inv00     = r_inv[0];
    assign o_inv01     = r_inv[1];
    assign o_inv02     = r_inv[2];
    assign o_inv10     = r_inv[3];
    assign o_inv11     = r_inv[4];
    assign o_inv12     = r_inv[5];
    assign o_inv20     = r_inv[6];
    assign o_inv21     = r_inv[7];
    assign o_inv22     = r_inv[8];
    assign o_det_value = r_det_o;
    assign o_singular  = r_sing_o;

`ifndef SYNTHESIS
    // every strobe comes from a matching earlier start transfer
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start, LATENCY))
        else $error("strobe without matching start");

    // a singular result has a zero determinant and zeros in the diagonal and in entries 01 and 12
    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_singular) |-> (o_det_value == '0 && o_inv00 == '0 &&
         o_inv11 == '0 && o_inv22 == '0 && o_inv01 == '0 && o_inv12 == '0))
        else $error("singular result not zeroed");

    // a nonsingular result has a nonzero determinant
    a_det_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_singular) |-> (o_det_value != '0))
        else $error("zero determinant without singular flag");
`endif

endmodule

[verif/tb_top.sv]
// Self-checking testbench for the 3x3 matrix inverse unit (adjugate method, Q16.16).
`timescale 1ns / 1ps
module tb_top;
    import m3i_pkg::*;

    typedef struct packed {
        logic [NUM_ENT-1:0][ENT_W-1:0] a;
    } matrix_t;

    typedef struct packed {
        logic [NUM_ENT-1:0][ENT_W-1:0] inv;
        logic [ENT_W-1:0]              det;
        logic                          singular;
    } inverse_t;

    localparam logic [ENT_W-1:0] ONE_Q = 32'h0001_0000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [NUM_ENT-1:0][ENT_W-1:0] drv_a = '0;
    logic o_strobe;
    logic [NUM_ENT-1:0][ENT_W-1:0] o_inv;
    logic [ENT_W-1:0] o_det_value;
    logic o_singular;

    matrix_t  pending_mats [$];
    inverse_t expected_invs [$];
    int       idle_pct = 0;
    int       err_count = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    matrix3x3_inverse_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_a00(drv_a[0]), .i_a01(drv_a[1]), .i_a02(drv_a[2]),
        .i_a10(drv_a[3]), .i_a11(drv_a[4]), .i_a12(drv_a[5]),
        .i_a20(drv_a[6]), .i_a21(drv_a[7]), .i_a22(drv_a[8]),
        .o_strobe(o_strobe),
        .o_inv00(o_inv[0]), .o_inv01(o_inv[1]), .o_inv02(o_inv[2]),
        .o_inv10(o_inv[3]), .o_inv11(o_inv[4]), .o_inv12(o_inv[5]),
        .o_inv20(o_inv[6]), .o_inv21(o_inv[7]), .o_inv22(o_inv[8]),
        .o_det_value(o_det_value), .o_singular(o_singular)
    );

    // saturate a sign/magnitude value to signed Q16.16
    function automatic logic [ENT_W-1:0] clamp_q16(input logic neg, input logic [127:0] mag);
        logic [ENT_W-1:0] res;
        if (neg) begin
            if (mag >= 128'h8000_0000) res = SAT_NEG;
            else                       res = ~mag[31:0] + 1'b1;
        end else begin
            if (mag > 128'h7FFF_FFFF)  res = SAT_POS;
            else                       res = mag[31:0];
        end
        return res;
    endfunction

    // exact cofactors and determinant, then truncating division per entry
    function automatic inverse_t invert_matrix(input matrix_t mx);
        int ia [NUM_ENT] = '{4, 5, 3, 2, 0, 1, 1, 2, 0};
        int ib [NUM_ENT] = '{8, 6, 7, 7, 8, 6, 5, 3, 4};
        int ic [NUM_ENT] = '{5, 3, 4, 1, 2, 0, 2, 0, 1};
        int id [NUM_ENT] = '{7, 8, 6, 8, 6, 7, 4, 5, 3};
        logic signed [127:0] e [NUM_ENT];
        logic signed [127:0] cf [NUM_ENT];
        logic signed [127:0] det;
        logic signed [ENT_W-1:0] t;
        logic [127:0] mag, dmag, cmag, quo;
        logic [63:0] dq;
        logic dneg, qneg;
        inverse_t r;
        for (int i = 0; i < NUM_ENT; i++) begin
            t = mx.a[i];
            e[i] = t;
        end
        for (int k = 0; k < NUM_ENT; k++)
            cf[k] = e[ia[k]] * e[ib[k]] - e[ic[k]] * e[id[k]];
        det = e[0] * cf[0] + e[1] * cf[1] + e[2] * cf[2];
        dneg = det < 0;
        mag = dneg ? -det : det;
        dq = mag[95:32];
        r.det = clamp_q16(dneg, {64'd0, dq});
        r.inv = '0;
        r.singular = (r.det == '0);
        if (!r.singular) begin
            if (dneg) dmag = (dq >= 64'h8000_0000) ? 128'h8000_0000 : {64'd0, dq};
            else      dmag = (dq > 64'h7FFF_FFFF)  ? 128'h7FFF_FFFF : {64'd0, dq};
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++) begin
                    cmag = (cf[j*3+i] < 0) ? -cf[j*3+i] : cf[j*3+i];
                    quo = cmag / dmag;
                    qneg = ((cf[j*3+i] < 0) != dneg) && (quo != 0);
                    r.inv[i*3+j] = clamp_q16(qneg, quo);
                end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [ENT_W-1:0] got,
                                   input logic [ENT_W-1:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    // driver: record each transfer, then present the next matrix or idle
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) begin
            expected_invs.push_back(invert_matrix(pending_mats.pop_front()));
        end
        if (i_rst_n && pending_mats.size() > 0 && $urandom_range(99) >= idle_pct) begin
            start <= 1'b1;
            drv_a <= pending_mats[0].a;
        end else begin
            start <= 1'b0;
        end
    end

    // monitor: every strobe must match the oldest prediction
    always @(posedge i_clk) begin
        inverse_t want;
        if (i_rst_n && o_strobe) begin
            if (expected_invs.size() == 0) begin
                report_mismatch("unexpected result", o_det_value, '0);
            end else begin
                want = expected_invs.pop_front();
                if (o_det_value !== want.det) report_mismatch("det", o_det_value, want.det);
                if (o_singular !== want.singular)
                    report_mismatch("singular", 32'(o_singular), 32'(want.singular));
                for (int i = 0; i < NUM_ENT; i++)
                    if (o_inv[i] !== want.inv[i])
                        report_mismatch($sformatf("inv[%0d]", i), o_inv[i], want.inv[i]);
            end
        end
    end

    function automatic logic [ENT_W-1:0] small_q(input int range_q);
        return ENT_W'($signed($urandom_range(2 * range_q)) - range_q);
    endfunction

    // random matrix of one of several shapes
    function automatic matrix_t random_matrix();
        matrix_t m;
        int shape;
        shape = $urandom_range(9);
        for (int i = 0; i < NUM_ENT; i++) begin
            case (shape)
                0, 1: begin
                    m.a[i] = $urandom();
                end
                2, 3, 4: begin
                    m.a[i] = small_q(8 * 65536);
                end
                5: begin
                    m.a[i] = small_q(256);
                end
                6: begin
                    m.a[i] = (i % 4 == 0) ? $urandom() : small_q(65536);
                end
                default: begin
                    m.a[i] = small_q(4 * 65536);
                end
            endcase
        end
        // rank-deficient: repeat a row, sometimes with a tweak
        if (shape >= 8) begin
            m.a[6] = m.a[0];
            m.a[7] = m.a[1];
            m.a[8] = m.a[2] + ((shape == 9) ? ENT_W'($urandom_range(3)) : '0);
        end
        return m;
    endfunction

    function automatic matrix_t diag(input logic [ENT_W-1:0] d0, input logic [ENT_W-1:0] d1,
                                     input logic [ENT_W-1:0] d2);
        matrix_t m;
        m.a = '0;
        m.a[0] = d0;
        m.a[4] = d1;
        m.a[8] = d2;
        return m;
    endfunction

    task automatic wait_drained();
        while (pending_mats.size() > 0 || expected_invs.size() > 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    initial begin
        matrix_t m;
        int phase_pct [4] = '{0, 61, 33, 0};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: identity, zero, extremes, tiny and saturating determinants
        pending_mats.push_back(diag(ONE_Q, ONE_Q, ONE_Q));
        m.a = '0;
        pending_mats.push_back(m);
        m.a = {NUM_ENT{SAT_POS}};
        pending_mats.push_back(m);
        m.a = {NUM_ENT{SAT_NEG}};
        pending_mats.push_back(m);
        m.a = {NUM_ENT{32'hFFFF_FFFF}};
        pending_mats.push_back(m);
        pending_mats.push_back(diag(SAT_POS, SAT_POS, SAT_POS));
        pending_mats.push_back(diag(SAT_NEG, SAT_POS, SAT_NEG));
        pending_mats.push_back(diag(SAT_NEG, SAT_NEG, SAT_NEG));
        pending_mats.push_back(diag(32'd1, 32'd1, 32'd1));
        pending_mats.push_back(diag(32'd256, 32'd256, 32'd256));
        pending_mats.push_back(diag(32'h0000_0100, ONE_Q, ONE_Q));
        pending_mats.push_back(diag(-ONE_Q, ONE_Q, ONE_Q));
        pending_mats.push_back(diag(32'h0002_0000, 32'h0000_8000, 32'hFFFC_0000));
        pending_mats.push_back(diag(32'h0000_0001, SAT_POS, ONE_Q));
        m.a = '{SAT_POS, SAT_NEG, SAT_POS, SAT_NEG, SAT_POS, SAT_NEG, SAT_POS, SAT_NEG, SAT_POS};
        pending_mats.push_back(m);
        m.a = '{SAT_NEG, SAT_POS, 32'd0, SAT_POS, SAT_NEG, SAT_POS, 32'd0, SAT_POS, SAT_NEG};
        pending_mats.push_back(m);
        m.a = '{32'h0002_0000, ONE_Q, 32'd0, ONE_Q, 32'h0003_0000, ONE_Q, 32'd0, ONE_Q,
                32'h0004_0000};
        pending_mats.push_back(m);
        m.a = '{ONE_Q, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 32'h0005_0000,
                32'h0006_0000, 32'h0007_0000, 32'h0008_0000, 32'h0009_0000};
        pending_mats.push_back(m);
        // pause until the directed part has fully drained
        wait_drained();

        // random phases at varying sender idle rates
        for (int p = 0; p < 4; p++) begin
            idle_pct = phase_pct[p];
            for (int n = 0; n < 425; n++) pending_mats.push_back(random_matrix());
            wait_drained();
        end

        if (err_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #4_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
